// ===== rtl/fte_pkg.sv =====
// fte_pkg: shared types, opcodes, status codes and entry helpers
// for the FAT12 table engine. No dependencies.
package fte_pkg;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] cluster;
		logic [11:0] entry_value;
		logic [12:0] byte_addr;
		logic [7:0]  byte_in;
	} fte_cmd_t;

	typedef struct packed {
		logic [11:0] result_value;
		logic [7:0]  byte_out;
		logic [1:0]  status;
	} fte_rsp_t;

	// one byte bank: write port and registered read port, byte addresses
	typedef struct packed {
		logic        we;
		logic [12:0] waddr;
		logic [7:0]  wdata;
		logic [12:0] raddr;
	} fte_bank_req_t;

	localparam logic [2:0] OP_READ    = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_NEXT    = 3'd2;
	localparam logic [2:0] OP_FIND    = 3'd3;
	localparam logic [2:0] OP_FREE    = 3'd4;
	localparam logic [2:0] OP_LD_BYTE = 3'd5;
	localparam logic [2:0] OP_RD_BYTE = 3'd6;
	localparam logic [2:0] OP_NOP     = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_BROKEN  = 2'd2;
	localparam logic [1:0] ST_NOFREE  = 2'd3;

	localparam logic [11:0] BAD_FIRST       = 12'hFF7;
	localparam logic [11:0] LAST_CLUSTER    = 12'hFFF;
	localparam logic [11:0] FIRST_CLUSTER   = 12'd2;
	localparam logic [11:0] MAX_CLUSTER_RST = 12'd2848;
	localparam logic [12:0] STEP_LAST       = 13'd4095;

	// byte offset of an entry: c + c/2
	function automatic logic [12:0] entry_off(input logic [11:0] c);
		return {1'b0, c} + {2'b00, c[11:1]};
	endfunction

	function automatic logic is_valid(input logic [11:0] c, input logic [11:0] max_c);
		return (c >= FIRST_CLUSTER) && (c <= max_c);
	endfunction

	// free, reserved, bad-cluster or end-of-chain marker: no further link to check
	function automatic logic is_terminal(input logic [11:0] v);
		return (v < FIRST_CLUSTER) || (v >= BAD_FIRST);
	endfunction

endpackage

// ===== rtl/fte_bank.sv =====
// fte_bank: one byte bank of the packed table, synchronous write,
// registered read. Uses fte_pkg for the request type.
module fte_bank #(
	parameter int TABLE_BYTES = 6144
) (
	input  logic                  clk,
	input  fte_pkg::fte_bank_req_t req,
	output logic [7:0]            rdata
);
	import fte_pkg::*;

	localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
	localparam int IW         = $clog2(BANK_DEPTH);

	logic [7:0] mem [BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[IW:1]] <= req.wdata;
		end
		rdata <= mem[req.raddr[IW:1]];
	end

endmodule

// ===== rtl/fte_ctrl.sv =====
// fte_ctrl: sequencer for the FAT12 table engine. Read-modify-write of
// entries over an even and an odd byte bank, chain walk, free scan, clear pass,
// byte load and byte read. Depends on fte_pkg.
module fte_ctrl #(
	parameter int TABLE_BYTES = 6144
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  fte_pkg::fte_cmd_t      cmd,
	output logic                   busy,
	output logic                   done,
	output fte_pkg::fte_rsp_t      rsp,
	input  logic                   cfg_we,
	input  logic [11:0]            cfg_wdata,
	output fte_pkg::fte_bank_req_t even_req,
	output fte_pkg::fte_bank_req_t odd_req,
	input  logic [7:0]             even_rdata,
	input  logic [7:0]             odd_rdata
);
	import fte_pkg::*;

	localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
	localparam int IW         = $clog2(BANK_DEPTH);
	localparam logic [IW-1:0] CLR_LAST = IW'(BANK_DEPTH - 1);
	localparam logic [12:0]   TB_LIMIT = 13'(TABLE_BYTES);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ENTRY = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_ISSUE = 3'd4;
	localparam logic [2:0] S_SCAN  = 3'd5;
	localparam logic [2:0] S_BYTE  = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [IW-1:0] clr_q, clr_d;
	logic [11:0]   max_q;
	logic [2:0]    op_q, op_d;
	logic [11:0]   clu_q, clu_d;
	logic [11:0]   cand_q, cand_d;
	logic [11:0]   val_q, val_d;
	logic [12:0]   addr_q, addr_d;
	logic [12:0]   steps_q, steps_d;
	logic [7:0]    lo_save_q, lo_save_d;
	logic [7:0]    hi_save_q, hi_save_d;
	logic          done_q, done_d;
	fte_rsp_t      rsp_q, rsp_d;

	// read side
	logic [11:0] rd_clu;
	logic        byte_rd;
	logic [12:0] rd_off, rd_off1, rd_even_addr, rd_odd_addr;
	logic        rd_off_odd_q, rd_c_odd_q, rd_lo_ok_q, rd_hi_ok_q;
	logic [7:0]  lo_b, hi_b;
	logic [11:0] ent;
	logic [7:0]  byte_val;

	// write side
	logic        wr_entry, ld_byte;
	logic [12:0] wr_off, wr_off1, wr_even_addr, wr_odd_addr;
	logic        wr_lo_ok, wr_hi_ok;
	logic [7:0]  old_lo, old_hi, new_lo, new_hi;
	logic [11:0] wr_val;

	always_comb begin
		rd_off       = entry_off(rd_clu);
		rd_off1      = rd_off + 13'd1;
		rd_even_addr = rd_off[0] ? rd_off1 : rd_off;
		rd_odd_addr  = rd_off[0] ? rd_off : rd_off1;
	end

	always_comb begin
		lo_b     = rd_lo_ok_q ? (rd_off_odd_q ? odd_rdata : even_rdata) : 8'h00;
		hi_b     = rd_hi_ok_q ? (rd_off_odd_q ? even_rdata : odd_rdata) : 8'h00;
		ent      = rd_c_odd_q ? {hi_b, lo_b[7:4]} : {hi_b[3:0], lo_b};
		byte_val = (addr_q < TB_LIMIT) ? (addr_q[0] ? odd_rdata : even_rdata) : 8'h00;
	end

	always_comb begin
		wr_off       = entry_off(clu_q);
		wr_off1      = wr_off + 13'd1;
		wr_lo_ok     = wr_off < TB_LIMIT;
		wr_hi_ok     = wr_off1 < TB_LIMIT;
		wr_even_addr = wr_off[0] ? wr_off1 : wr_off;
		wr_odd_addr  = wr_off[0] ? wr_off : wr_off1;
		old_lo       = (state_q == S_CHECK) ? lo_save_q : lo_b;
		old_hi       = (state_q == S_CHECK) ? hi_save_q : hi_b;
		wr_val       = (op_q == OP_WRITE) ? val_q : 12'd0;
		if (clu_q[0]) begin
			new_lo = {wr_val[3:0], old_lo[3:0]};
			new_hi = wr_val[11:4];
		end else begin
			new_lo = wr_val[7:0];
			new_hi = {old_hi[7:4], wr_val[11:8]};
		end
	end

	always_comb begin
		even_req.raddr = byte_rd ? cmd.byte_addr : rd_even_addr;
		odd_req.raddr  = byte_rd ? cmd.byte_addr : rd_odd_addr;
		even_req.we    = 1'b0;
		odd_req.we     = 1'b0;
		even_req.waddr = wr_even_addr;
		odd_req.waddr  = wr_odd_addr;
		even_req.wdata = wr_off[0] ? new_hi : new_lo;
		odd_req.wdata  = wr_off[0] ? new_lo : new_hi;
		if (state_q == S_CLEAR) begin
			even_req.we    = 1'b1;
			odd_req.we     = 1'b1;
			even_req.waddr = 13'({clr_q, 1'b0});
			odd_req.waddr  = 13'({clr_q, 1'b1});
			even_req.wdata = 8'h00;
			odd_req.wdata  = 8'h00;
		end else if (wr_entry) begin
			even_req.we = wr_off[0] ? wr_hi_ok : wr_lo_ok;
			odd_req.we  = wr_off[0] ? wr_lo_ok : wr_hi_ok;
		end else if (ld_byte) begin
			even_req.we    = !cmd.byte_addr[0] && (cmd.byte_addr < TB_LIMIT);
			odd_req.we     = cmd.byte_addr[0] && (cmd.byte_addr < TB_LIMIT);
			even_req.waddr = cmd.byte_addr;
			odd_req.waddr  = cmd.byte_addr;
			even_req.wdata = cmd.byte_in;
			odd_req.wdata  = cmd.byte_in;
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		op_d      = op_q;
		clu_d     = clu_q;
		cand_d    = cand_q;
		val_d     = val_q;
		addr_d    = addr_q;
		steps_d   = steps_q;
		lo_save_d = lo_save_q;
		hi_save_d = hi_save_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		rd_clu    = clu_q;
		byte_rd   = 1'b0;
		wr_entry  = 1'b0;
		ld_byte   = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				clr_d = clr_q + 1'b1;
				if (clr_q == CLR_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				rd_clu  = (cmd.op == OP_FIND) ? FIRST_CLUSTER : cmd.cluster;
				byte_rd = (cmd.op == OP_RD_BYTE);
				if (start) begin
					op_d    = cmd.op;
					clu_d   = cmd.cluster;
					val_d   = cmd.entry_value;
					addr_d  = cmd.byte_addr;
					steps_d = 13'd0;
					rsp_d   = '{result_value: 12'd0, byte_out: 8'h00, status: ST_OK};
					unique case (cmd.op) inside
						OP_READ, OP_WRITE, OP_NEXT, OP_FREE: begin
							if (!is_valid(cmd.cluster, max_q)) begin
								rsp_d.status = ST_INVALID;
								done_d       = 1'b1;
							end else begin
								state_d = S_ENTRY;
							end
						end
						OP_FIND: begin
							clu_d = FIRST_CLUSTER;
							if (max_q < FIRST_CLUSTER) begin
								rsp_d.status = ST_NOFREE;
								done_d       = 1'b1;
							end else begin
								state_d = S_SCAN;
							end
						end
						OP_LD_BYTE: begin
							ld_byte = 1'b1;
							done_d  = 1'b1;
						end
						OP_RD_BYTE: begin
							state_d = S_BYTE;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_ENTRY: begin
				rd_clu    = ent;
				cand_d    = ent;
				lo_save_d = lo_b;
				hi_save_d = hi_b;
				if (op_q == OP_READ) begin
					rsp_d.result_value = ent;
					done_d             = 1'b1;
					state_d            = S_IDLE;
				end else if (op_q == OP_WRITE) begin
					wr_entry           = 1'b1;
					rsp_d.result_value = val_q;
					done_d             = 1'b1;
					state_d            = S_IDLE;
				end else if (is_terminal(ent)) begin
					if (op_q == OP_NEXT) begin
						rsp_d.result_value = ent;
						done_d             = 1'b1;
						state_d            = S_IDLE;
					end else begin
						wr_entry = 1'b1;
						clu_d    = ent;
						steps_d  = steps_q + 13'd1;
						if (is_valid(ent, max_q) && (steps_q < STEP_LAST)) begin
							state_d = S_ISSUE;
						end else begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
					end
				end else if (!is_valid(ent, max_q)) begin
					rsp_d.status = ST_BROKEN;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				// ent holds the entry of the candidate link
				if ((ent < FIRST_CLUSTER) || ((ent < BAD_FIRST) && (ent > max_q))) begin
					rsp_d.status = ST_BROKEN;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else if (op_q == OP_NEXT) begin
					rsp_d.result_value = cand_q;
					done_d             = 1'b1;
					state_d            = S_IDLE;
				end else begin
					wr_entry = 1'b1;
					clu_d    = cand_q;
					steps_d  = steps_q + 13'd1;
					if (steps_q < STEP_LAST) begin
						state_d = S_ISSUE;
					end else begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_ISSUE: begin
				state_d = S_ENTRY;
			end
			S_SCAN: begin
				rd_clu = clu_q + 12'd1;
				if (ent == 12'd0) begin
					rsp_d.result_value = clu_q;
					done_d             = 1'b1;
					state_d            = S_IDLE;
				end else if ((clu_q == max_q) || (clu_q == LAST_CLUSTER)) begin
					rsp_d.status = ST_NOFREE;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					clu_d = clu_q + 12'd1;
				end
			end
			S_BYTE: begin
				rsp_d.byte_out = byte_val;
				done_d         = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			max_q   <= MAX_CLUSTER_RST;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		clu_q        <= clu_d;
		cand_q       <= cand_d;
		val_q        <= val_d;
		addr_q       <= addr_d;
		steps_q      <= steps_d;
		lo_save_q    <= lo_save_d;
		hi_save_q    <= hi_save_d;
		rsp_q        <= rsp_d;
		rd_off_odd_q <= rd_off[0];
		rd_c_odd_q   <= rd_clu[0];
		rd_lo_ok_q   <= rd_off < TB_LIMIT;
		rd_hi_ok_q   <= rd_off1 < TB_LIMIT;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/fat12_table_engine_top.sv =====
// fat12_table_engine_top: FAT12 allocation table engine, top level.
// Instantiates fte_ctrl and two fte_bank byte banks. Depends on fte_pkg.
//
// The table lives in two byte banks (even and odd byte addresses), so an
// entry's two bytes are read together and written back together.
// After reset a clearing pass zeroes the table; busy is high during it,
// and cfg_we is taken as always. A transaction is accepted when start is
// high and busy is low; its result appears on result with done high for
// exactly one cycle, which the receiver must take. Invalid cluster, load
// byte and the unused op complete from idle; read, write, read byte and a
// terminal next complete after the registered bank read; next with a link
// check also reads the linked entry; find free reads entries in turn from
// cluster 2; free chain reads each entry, checks a non-marker link by
// reading its entry, clears the entry unless that link is broken, passes
// an issue state and goes on until a marker, a broken link or the step limit.
module fat12_table_engine_top #(
	parameter int TABLE_BYTES = 6144
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fte_pkg::fte_cmd_t cmd,
	output logic              busy,
	output logic              done,
	output fte_pkg::fte_rsp_t result,
	input  logic              cfg_we,
	input  logic [11:0]       cfg_wdata
);
	import fte_pkg::*;

	fte_bank_req_t even_req, odd_req;
	logic [7:0]    even_rdata, odd_rdata;

	fte_ctrl #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.rsp        (result),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.even_req   (even_req),
		.odd_req    (odd_req),
		.even_rdata (even_rdata),
		.odd_rdata  (odd_rdata)
	);

	fte_bank #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_even_bank (
		.clk   (clk),
		.req   (even_req),
		.rdata (even_rdata)
	);

	fte_bank #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_odd_bank (
		.clk   (clk),
		.req   (odd_req),
		.rdata (odd_rdata)
	);

endmodule
